[rtl/glw_pkg.sv]
// Shared types and constants for the greedy line wrapper.
// No dependencies.
package glw_pkg;

  typedef struct packed {
    logic        kind;
    logic [20:0] code_point;
    logic [1:0]  col_width;
  } char_item_t;

  typedef struct packed {
    logic [15:0] line_start;
    logic [15:0] line_end;
    logic        final_line;
  } line_item_t;

  localparam logic        KIND_CHAR = 1'b0;
  localparam logic        KIND_END  = 1'b1;

  localparam logic [20:0] CP_NUL    = 21'd0;
  localparam logic [20:0] CP_NL     = 21'd10;
  localparam logic [20:0] CP_FMT    = 21'd25;
  localparam logic [20:0] CP_SPACE  = 21'd32;
  localparam logic [20:0] CP_LC_A   = 21'd97;
  localparam logic [20:0] CP_LC_B   = 21'd98;
  localparam logic [20:0] CP_LC_I   = 21'd105;
  localparam logic [20:0] CP_LC_O   = 21'd111;
  localparam logic [20:0] CP_LC_U   = 21'd117;
  localparam logic [20:0] CP_RBRACE = 21'd125;

  localparam logic [11:0] LINE_WIDTH_RST = 12'd80;
  localparam logic [12:0] COL_MAX        = 13'h1FFF;

endpackage

[rtl/greedy_line_wrapper.sv]
// Greedy line wrapper: one character per cycle while char_ready, emits line spans.
// Each (start, end) span is registered into line_data, or skid_data if the head waits.
// A two-entry output buffer keeps char_ready high while one finished line waits.
// Reset (rst, synchronous, active high): all text state cleared, line_width = 80.
// Depends on glw_pkg.
module greedy_line_wrapper #(
  parameter int unsigned MAX_CHARS = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [11:0]         cfg_wdata,
  input  logic                char_valid,
  output logic                char_ready,
  input  glw_pkg::char_item_t char_data,
  output logic                line_valid,
  input  logic                line_ready,
  output glw_pkg::line_item_t line_data
);
  import glw_pkg::*;

  localparam logic [15:0] POS_LIMIT = (MAX_CHARS < 65535) ? 16'(MAX_CHARS) : 16'hFFFF;

  logic [11:0] line_width;
  logic [15:0] char_position, char_position_next;
  logic [15:0] line_start_pos, line_start_pos_next;
  logic [15:0] space_position, space_position_next;
  logic        space_seen, space_seen_next;
  logic [12:0] cols_before_space, cols_before_space_next;
  logic [12:0] columns_used, columns_used_next;
  logic        in_fmt, in_fmt_next;
  logic        text_stopped, text_stopped_next;

  logic        skid_valid;
  line_item_t  skid_data;

  logic        fire, emit, pop;
  line_item_t  res;
  logic [1:0]  cols;
  logic [13:0] sum_cols, dec, cu_sum;
  logic [12:0] cu_work;
  logic        closes;

  function automatic logic [15:0] pos_inc(input logic [15:0] p);
    pos_inc = (p >= POS_LIMIT) ? POS_LIMIT : p + 16'd1;
  endfunction

  assign char_ready = !skid_valid;
  assign fire       = char_valid && char_ready;
  assign pop        = line_valid && line_ready;

  assign cols     = (char_data.col_width == 2'd3) ? 2'd2 : char_data.col_width;
  assign sum_cols = {1'b0, columns_used} + {12'd0, cols};
  assign dec      = {1'b0, cols_before_space} + 14'd1;
  assign closes   = (char_data.code_point == CP_LC_U) || (char_data.code_point == CP_LC_A) ||
                    (char_data.code_point == CP_LC_I) || (char_data.code_point == CP_LC_B) ||
                    (char_data.code_point == CP_LC_O) || (char_data.code_point == CP_RBRACE);

  always_comb begin
    char_position_next     = char_position;
    line_start_pos_next    = line_start_pos;
    space_position_next    = space_position;
    space_seen_next        = space_seen;
    cols_before_space_next = cols_before_space;
    columns_used_next      = columns_used;
    in_fmt_next            = in_fmt;
    text_stopped_next      = text_stopped;
    emit                   = 1'b0;
    res                    = '{line_start: line_start_pos, line_end: char_position,
                               final_line: 1'b0};
    cu_work                = columns_used;
    cu_sum                 = '0;
    if (char_data.kind == KIND_END) begin
      emit                   = 1'b1;
      res.final_line         = 1'b1;
      char_position_next     = '0;
      line_start_pos_next    = '0;
      space_position_next    = '0;
      space_seen_next        = 1'b0;
      cols_before_space_next = '0;
      columns_used_next      = '0;
      in_fmt_next            = 1'b0;
      text_stopped_next      = 1'b0;
    end else if (text_stopped) begin
      emit = 1'b0;
    end else if (in_fmt) begin
      char_position_next = pos_inc(char_position);
      if (closes) begin
        in_fmt_next = 1'b0;
      end
    end else if (char_data.code_point == CP_FMT) begin
      in_fmt_next        = 1'b1;
      char_position_next = pos_inc(char_position);
    end else if (char_data.code_point == CP_NUL) begin
      text_stopped_next = 1'b1;
    end else if (char_data.code_point == CP_NL) begin
      char_position_next  = pos_inc(char_position);
      emit                = 1'b1;
      res.line_end        = char_position_next;
      line_start_pos_next = char_position_next;
      space_seen_next     = 1'b0;
      columns_used_next   = '0;
    end else begin
      if (sum_cols > {2'b00, line_width}) begin
        emit = 1'b1;
        if (space_seen) begin
          res.line_end        = space_position;
          line_start_pos_next = pos_inc(space_position);
          space_seen_next     = 1'b0;
          cu_work = ({1'b0, columns_used} > dec) ? 13'({1'b0, columns_used} - dec) : 13'd0;
        end else begin
          line_start_pos_next = char_position;
          cu_work             = '0;
        end
      end
      if (char_data.code_point == CP_SPACE) begin
        space_position_next    = char_position;
        space_seen_next        = 1'b1;
        cols_before_space_next = cu_work;
      end
      cu_sum             = {1'b0, cu_work} + {12'd0, cols};
      columns_used_next  = cu_sum[13] ? COL_MAX : cu_sum[12:0];
      char_position_next = pos_inc(char_position);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      line_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position     <= '0;
      line_start_pos    <= '0;
      space_position    <= '0;
      space_seen        <= 1'b0;
      cols_before_space <= '0;
      columns_used      <= '0;
      in_fmt            <= 1'b0;
      text_stopped      <= 1'b0;
    end else if (fire) begin
      char_position     <= char_position_next;
      line_start_pos    <= line_start_pos_next;
      space_position    <= space_position_next;
      space_seen        <= space_seen_next;
      cols_before_space <= cols_before_space_next;
      columns_used      <= columns_used_next;
      in_fmt            <= in_fmt_next;
      text_stopped      <= text_stopped_next;
    end
  end

  // two-entry output buffer: line_data is the head, skid_data the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!line_valid) begin
      line_valid <= fire && emit;
    end else if (pop && skid_valid) begin
      skid_valid <= 1'b0;
    end else if (pop) begin
      line_valid <= fire && emit;
    end else if (fire && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!line_valid || (pop && !skid_valid)) begin
      line_data <= res;
    end else if (pop) begin
      line_data <= skid_data;
    end
    if (line_valid && !pop && fire && emit) begin
      skid_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> line_valid)
    else $error("skid entry held without head entry");

  a_start_not_past_pos: assert property (@(posedge clk) disable iff (rst)
    line_start_pos <= char_position)
    else $error("line start beyond character position");

  a_stop_excludes_fmt: assert property (@(posedge clk) disable iff (rst)
    !(text_stopped && in_fmt))
    else $error("stopped text inside formatting run");
`endif

endmodule
